>>> hdl/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg: shared types and constants
// Register indexes, product-sequence codes and the step table of the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package rti_pkg;

  localparam int CoordWidth  = 32;
  localparam int FracBits    = 16;
  localparam int EpsWidth    = 16;
  localparam int CfgIdxWidth = 3;
  localparam int NumSteps    = 24;
  localparam int StepWidth   = 5;
  localparam int StepDet     = 8;   // last step of the determinant
  localparam int StepQ       = 9;   // first step after the determinant check

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_DIR_X    = 3'd3,
    CFG_DIR_Y    = 3'd4,
    CFG_DIR_Z    = 3'd5,
    CFG_CULL     = 3'd6,
    CFG_DET_EPS  = 3'd7
  } cfg_idx_e;

  // operand sources of the shared multiplier
  typedef enum logic [4:0] {
    SRC_D0, SRC_D1, SRC_D2,
    SRC_E1_0, SRC_E1_1, SRC_E1_2,
    SRC_E2_0, SRC_E2_1, SRC_E2_2,
    SRC_T0, SRC_T1, SRC_T2,
    SRC_P0, SRC_P1, SRC_P2,
    SRC_Q0, SRC_Q1, SRC_Q2
  } src_e;

  localparam int NumSrc = 18;

  // accumulator destinations
  typedef enum logic [3:0] {
    DST_NONE, DST_P0, DST_P1, DST_P2, DST_DET,
    DST_Q0, DST_Q1, DST_Q2, DST_NU, DST_NV, DST_NT
  } dst_e;

  typedef struct packed {
    src_e a;
    src_e b;
    logic sub;
    logic first;
    dst_e dst;
  } step_t;

  function automatic step_t mk(input src_e a, input src_e b, input logic sub,
                               input logic first, input dst_e dst);
    step_t s;
    s.a = a; s.b = b; s.sub = sub; s.first = first; s.dst = dst;
    return s;
  endfunction

  // P = D x E2, det = E1.P, Q = T x E1, then T.P, D.Q, E2.Q
  function automatic step_t step_info(input logic [StepWidth-1:0] idx);
    step_t s;
    case (idx)
      5'd0:  s = mk(SRC_D1,   SRC_E2_2, 1'b0, 1'b1, DST_NONE);
      5'd1:  s = mk(SRC_D2,   SRC_E2_1, 1'b1, 1'b0, DST_P0);
      5'd2:  s = mk(SRC_D2,   SRC_E2_0, 1'b0, 1'b1, DST_NONE);
      5'd3:  s = mk(SRC_D0,   SRC_E2_2, 1'b1, 1'b0, DST_P1);
      5'd4:  s = mk(SRC_D0,   SRC_E2_1, 1'b0, 1'b1, DST_NONE);
      5'd5:  s = mk(SRC_D1,   SRC_E2_0, 1'b1, 1'b0, DST_P2);
      5'd6:  s = mk(SRC_E1_0, SRC_P0,   1'b0, 1'b1, DST_NONE);
      5'd7:  s = mk(SRC_E1_1, SRC_P1,   1'b0, 1'b0, DST_NONE);
      5'd8:  s = mk(SRC_E1_2, SRC_P2,   1'b0, 1'b0, DST_DET);
      5'd9:  s = mk(SRC_T1,   SRC_E1_2, 1'b0, 1'b1, DST_NONE);
      5'd10: s = mk(SRC_T2,   SRC_E1_1, 1'b1, 1'b0, DST_Q0);
      5'd11: s = mk(SRC_T2,   SRC_E1_0, 1'b0, 1'b1, DST_NONE);
      5'd12: s = mk(SRC_T0,   SRC_E1_2, 1'b1, 1'b0, DST_Q1);
      5'd13: s = mk(SRC_T0,   SRC_E1_1, 1'b0, 1'b1, DST_NONE);
      5'd14: s = mk(SRC_T1,   SRC_E1_0, 1'b1, 1'b0, DST_Q2);
      5'd15: s = mk(SRC_T0,   SRC_P0,   1'b0, 1'b1, DST_NONE);
      5'd16: s = mk(SRC_T1,   SRC_P1,   1'b0, 1'b0, DST_NONE);
      5'd17: s = mk(SRC_T2,   SRC_P2,   1'b0, 1'b0, DST_NU);
      5'd18: s = mk(SRC_D0,   SRC_Q0,   1'b0, 1'b1, DST_NONE);
      5'd19: s = mk(SRC_D1,   SRC_Q1,   1'b0, 1'b0, DST_NONE);
      5'd20: s = mk(SRC_D2,   SRC_Q2,   1'b0, 1'b0, DST_NV);
      5'd21: s = mk(SRC_E2_0, SRC_Q0,   1'b0, 1'b1, DST_NONE);
      5'd22: s = mk(SRC_E2_1, SRC_Q1,   1'b0, 1'b0, DST_NONE);
      5'd23: s = mk(SRC_E2_2, SRC_Q2,   1'b0, 1'b0, DST_NT);
      default: s = mk(SRC_D0, SRC_D0,   1'b0, 1'b1, DST_NONE);
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> hdl/rti_tri_if.sv
// ----------------------------------------------------------------------------
// rti_tri_if: triangle request channel
// valid/ready handshake carrying the three vertices and the new-ray flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface rti_tri_if #(
  parameter int CW = 32
);
  logic                 valid;
  logic                 ready;
  logic                 new_ray;
  logic signed [CW-1:0] a_x, a_y, a_z;
  logic signed [CW-1:0] b_x, b_y, b_z;
  logic signed [CW-1:0] c_x, c_y, c_z;

  modport source (output valid, new_ray, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  input ready);
  modport sink   (input valid, new_ray, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/rti_res_if.sv
// ----------------------------------------------------------------------------
// rti_res_if: intersection result channel
// valid/ready handshake carrying hit flag, closest distance and barycentrics.
// ----------------------------------------------------------------------------
`default_nettype none

interface rti_res_if #(
  parameter int CW = 32,
  parameter int F  = 16
);
  logic          valid;
  logic          ready;
  logic          hit;
  logic [CW-2:0] closest_t;
  logic [F:0]    bary_u;
  logic [F:0]    bary_v;

  modport source (output valid, hit, closest_t, bary_u, bary_v, input ready);
  modport sink   (input valid, hit, closest_t, bary_u, bary_v, output ready);
endinterface

`default_nettype wire

>>> hdl/rti_front.sv
// ----------------------------------------------------------------------------
// rti_front: request intake
// Forms saturated edge and origin vectors and buffers them in a 2-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rti_front
  import rti_pkg::*;
#(
  parameter int CW = CoordWidth,
  parameter int DW = 9 * CW + 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  rti_tri_if.sink                   tri_i,
  input  wire logic signed [CW-1:0] origin_x_i,
  input  wire logic signed [CW-1:0] origin_y_i,
  input  wire logic signed [CW-1:0] origin_z_i,
  output logic                      q_valid_o,
  input  wire logic                 q_ready_i,
  output logic [DW-1:0]             q_data_o
);

  localparam logic signed [CW:0] MaxE = {2'b00, {(CW-1){1'b1}}};

  function automatic logic signed [CW-1:0] sat_sub(input logic signed [CW-1:0] x,
                                                   input logic signed [CW-1:0] y);
    logic signed [CW:0] d;
    d = {x[CW-1], x} - {y[CW-1], y};
    if (d > MaxE) return MaxE[CW-1:0];
    if (d < -MaxE) return -MaxE[CW-1:0];
    return d[CW-1:0];
  endfunction

  logic [DW-1:0] ent_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          push, pop;
  logic [DW-1:0] wdata;

  assign tri_i.ready = (cnt_q != 2'd2);
  assign push        = tri_i.valid && tri_i.ready;
  assign pop         = q_valid_o && q_ready_i;
  assign q_valid_o   = (cnt_q != 2'd0);
  assign q_data_o    = ent_q[rd_ptr_q];

  assign wdata = {tri_i.new_ray,
                  sat_sub(tri_i.b_x, tri_i.a_x), sat_sub(tri_i.b_y, tri_i.a_y),
                  sat_sub(tri_i.b_z, tri_i.a_z),
                  sat_sub(tri_i.c_x, tri_i.a_x), sat_sub(tri_i.c_y, tri_i.a_y),
                  sat_sub(tri_i.c_z, tri_i.a_z),
                  sat_sub(origin_x_i, tri_i.a_x), sat_sub(origin_y_i, tri_i.a_y),
                  sat_sub(origin_z_i, tri_i.a_z)};

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_ptr_q] <= wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

>>> hdl/rti_div.sv
// ----------------------------------------------------------------------------
// rti_div: restoring divider
// Unsigned (num << F) / den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rti_div
  import rti_pkg::*;
#(
  parameter int CW = CoordWidth,
  parameter int F  = FracBits,
  parameter int QW = CW - 1 + F
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [CW-2:0] num_i,
  input  wire logic [CW-2:0] den_i,
  output logic               done_o,
  output logic [QW-1:0]      quo_o
);

  localparam int CntW = $clog2(QW + 1);

  logic [CW-2:0]   rem_q;
  logic [QW-1:0]   sh_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [CW-1:0]   r2;
  logic [CW-1:0]   r2_sub;
  logic            ge;

  assign r2     = {rem_q, sh_q[QW-1]};
  assign r2_sub = r2 - {1'b0, den_i};
  assign ge     = (r2 >= {1'b0, den_i});
  assign done_o = done_q;
  assign quo_o  = sh_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      sh_q  <= {num_i, {F{1'b0}}};
    end else if (busy_q) begin
      rem_q <= ge ? r2_sub[CW-2:0] : r2[CW-2:0];
      sh_q  <= {sh_q[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/rti_back.sv
// ----------------------------------------------------------------------------
// rti_back: intersection sequencer
// Shared multiplier-accumulator, determinant test, three divides, hit update.
// ----------------------------------------------------------------------------
`default_nettype none

module rti_back
  import rti_pkg::*;
#(
  parameter int CW = CoordWidth,
  parameter int F  = FracBits,
  parameter int DW = 9 * CW + 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 q_valid_i,
  output logic                      q_ready_o,
  input  wire logic [DW-1:0]        q_data_i,
  input  wire logic signed [CW-1:0] dir_x_i,
  input  wire logic signed [CW-1:0] dir_y_i,
  input  wire logic signed [CW-1:0] dir_z_i,
  input  wire logic                 cull_i,
  input  wire logic [EpsWidth-1:0]  eps_i,
  rti_res_if.source                 res_o
);

  localparam int AW = CW + 2;
  localparam int QW = CW - 1 + F;
  localparam logic [CW-1:0]        MaxV = {1'b0, {(CW-1){1'b1}}};
  localparam logic [2*CW-1:0]      MaxP = {{(CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [AW-1:0] MaxA = {3'b000, {(CW-1){1'b1}}};
  localparam logic [QW-1:0]        MaxQ = {{(QW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [CW:0]   OneS = (CW+1)'(1) << F;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL   = 8'b0000_0010,
    S_ACC   = 8'b0000_0100,
    S_CHECK = 8'b0000_1000,
    S_DIVGO = 8'b0001_0000,
    S_DIVW  = 8'b0010_0000,
    S_EVAL  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e               state_q;
  logic [StepWidth-1:0] step_q;
  logic [1:0]           sel_q;
  logic                 ok_q;
  logic [CW-2:0]        closest_q;

  logic signed [CW-1:0] e1_q [3], e2_q [3], tv_q [3], p_q [3], qq_q [3];
  logic signed [CW-1:0] det_q, nu_q, nv_q, nt_q, u_q, v_q, t_q;
  logic signed [AW-1:0] acc_q;
  logic [2*CW-1:0]      prod_q;
  logic                 neg_q;

  logic                 out_valid_q, hit_q;
  logic [CW-2:0]        ct_q;
  logic [F:0]           bu_q, bv_q;

  // operand selection
  step_t                st;
  logic signed [CW-1:0] ops [NumSrc];
  logic signed [CW-1:0] opa, opb;
  logic [CW-1:0]        amag, bmag;

  assign st = step_info(step_q);
  assign ops[SRC_D0] = dir_x_i;   assign ops[SRC_D1] = dir_y_i;   assign ops[SRC_D2] = dir_z_i;
  assign ops[SRC_E1_0] = e1_q[0]; assign ops[SRC_E1_1] = e1_q[1]; assign ops[SRC_E1_2] = e1_q[2];
  assign ops[SRC_E2_0] = e2_q[0]; assign ops[SRC_E2_1] = e2_q[1]; assign ops[SRC_E2_2] = e2_q[2];
  assign ops[SRC_T0] = tv_q[0];   assign ops[SRC_T1] = tv_q[1];   assign ops[SRC_T2] = tv_q[2];
  assign ops[SRC_P0] = p_q[0];    assign ops[SRC_P1] = p_q[1];    assign ops[SRC_P2] = p_q[2];
  assign ops[SRC_Q0] = qq_q[0];   assign ops[SRC_Q1] = qq_q[1];   assign ops[SRC_Q2] = qq_q[2];
  assign opa  = ops[st.a];
  assign opb  = ops[st.b];
  assign amag = opa[CW-1] ? CW'(-opa) : CW'(opa);
  assign bmag = opb[CW-1] ? CW'(-opb) : CW'(opb);

  // product scaling and accumulate
  logic [2*CW-1:0]      shifted;
  logic [CW-1:0]        mval;
  logic signed [AW-1:0] mterm, acc_d, acc_sat;

  always_comb begin
    shifted = prod_q >> F;
    mval    = (shifted > MaxP) ? MaxV : shifted[CW-1:0];
    mterm   = (neg_q ^ st.sub) ? -$signed({2'b00, mval}) : $signed({2'b00, mval});
    acc_d   = (st.first ? '0 : acc_q) + mterm;
    if (acc_d > MaxA) acc_sat = MaxA;
    else if (acc_d < -MaxA) acc_sat = -MaxA;
    else acc_sat = acc_d;
  end

  // determinant test
  logic signed [AW-1:0] det_x, det_abs, eps_x;
  logic                 det_ok;

  always_comb begin
    det_x   = AW'(det_q);
    det_abs = det_q[CW-1] ? -det_x : det_x;
    eps_x   = $signed({{(AW-EpsWidth){1'b0}}, eps_i});
    det_ok  = (det_q != '0) && (cull_i ? !(det_x < eps_x) : !(det_abs < eps_x));
  end

  // divider hookup
  logic signed [CW-1:0] num_sel, div_res;
  logic [CW-1:0]        num_mag, den_mag;
  logic [QW-1:0]        quo, quo_sat;
  logic                 div_done, div_neg;

  always_comb begin
    case (sel_q)
      2'd0:    num_sel = nu_q;
      2'd1:    num_sel = nv_q;
      default: num_sel = nt_q;
    endcase
    num_mag = num_sel[CW-1] ? CW'(-num_sel) : CW'(num_sel);
    den_mag = det_q[CW-1] ? CW'(-det_q) : CW'(det_q);
    div_neg = num_sel[CW-1] ^ det_q[CW-1];
    quo_sat = (quo > MaxQ) ? MaxQ : quo;
    div_res = div_neg ? -$signed(quo_sat[CW-1:0]) : $signed(quo_sat[CW-1:0]);
  end

  rti_div #(.CW(CW), .F(F), .QW(QW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_DIVGO),
    .num_i   (num_mag[CW-2:0]),
    .den_i   (den_mag[CW-2:0]),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // final acceptance
  logic signed [CW:0] u_x, v_x, uv;
  logic               hit_ok;

  always_comb begin
    u_x    = {u_q[CW-1], u_q};
    v_x    = {v_q[CW-1], v_q};
    uv     = u_x + v_x;
    hit_ok = !u_q[CW-1] && !(u_x > OneS) && !v_q[CW-1] && !(uv > OneS) &&
             !t_q[CW-1] && (t_q[CW-2:0] < closest_q);
  end

  logic out_free;
  assign out_free  = !out_valid_q || res_o.ready;
  assign q_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        for (int k = 0; k < 3; k++) begin
          e1_q[k] <= q_data_i[(9-k)*CW-1 -: CW];
          e2_q[k] <= q_data_i[(6-k)*CW-1 -: CW];
          tv_q[k] <= q_data_i[(3-k)*CW-1 -: CW];
        end
      end
      S_MUL: begin
        prod_q <= amag * bmag;
        neg_q  <= opa[CW-1] ^ opb[CW-1];
      end
      S_ACC: begin
        acc_q <= acc_d;
        case (st.dst)
          DST_P0:  p_q[0]  <= acc_sat[CW-1:0];
          DST_P1:  p_q[1]  <= acc_sat[CW-1:0];
          DST_P2:  p_q[2]  <= acc_sat[CW-1:0];
          DST_DET: det_q   <= acc_sat[CW-1:0];
          DST_Q0:  qq_q[0] <= acc_sat[CW-1:0];
          DST_Q1:  qq_q[1] <= acc_sat[CW-1:0];
          DST_Q2:  qq_q[2] <= acc_sat[CW-1:0];
          DST_NU:  nu_q    <= acc_sat[CW-1:0];
          DST_NV:  nv_q    <= acc_sat[CW-1:0];
          DST_NT:  nt_q    <= acc_sat[CW-1:0];
          default: ;
        endcase
      end
      S_DIVW: begin
        if (div_done) begin
          case (sel_q)
            2'd0:    u_q <= div_res;
            2'd1:    v_q <= div_res;
            default: t_q <= div_res;
          endcase
        end
      end
      S_DONE: begin
        if (out_free) begin
          hit_q <= ok_q;
          ct_q  <= closest_q;
          bu_q  <= ok_q ? u_q[F:0] : '0;
          bv_q  <= ok_q ? v_q[F:0] : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      sel_q       <= 2'd0;
      ok_q        <= 1'b0;
      closest_q   <= '1;
      out_valid_q <= 1'b0;
    end else begin
      // a new result in DONE takes over the output register
      if (res_o.ready && state_q != S_DONE) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            if (q_data_i[DW-1]) closest_q <= '1;
            step_q  <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: state_q <= S_ACC;
        S_ACC: begin
          step_q <= step_q + 1'b1;
          if (step_q == StepWidth'(StepDet)) state_q <= S_CHECK;
          else if (step_q == StepWidth'(NumSteps - 1)) begin
            sel_q   <= 2'd0;
            state_q <= S_DIVGO;
          end else state_q <= S_MUL;
        end
        S_CHECK: begin
          if (det_ok) begin
            step_q  <= StepWidth'(StepQ);
            state_q <= S_MUL;
          end else begin
            ok_q    <= 1'b0;
            state_q <= S_DONE;
          end
        end
        S_DIVGO: state_q <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            if (sel_q == 2'd2) state_q <= S_EVAL;
            else begin
              sel_q   <= sel_q + 2'd1;
              state_q <= S_DIVGO;
            end
          end
        end
        S_EVAL: begin
          ok_q <= hit_ok;
          if (hit_ok) closest_q <= t_q[CW-2:0];
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.hit       = hit_q;
  assign res_o.closest_t = ct_q;
  assign res_o.bary_u    = bu_q;
  assign res_o.bary_v    = bv_q;

  // a miss carries zero barycentrics
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !hit_q) |-> (bu_q == '0 && bv_q == '0))
    else $error("miss with nonzero barycentrics");

  // an accepted hit strictly shortens the closest distance
  a_closer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL && hit_ok) |=> (closest_q < $past(closest_q)))
    else $error("hit did not shorten closest distance");

  // a hit lies inside the triangle
  a_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && hit_q) |-> ({1'b0, bu_q} + {1'b0, bv_q} <= (F+2)'(OneS)))
    else $error("hit outside triangle");

endmodule

`default_nettype wire

>>> hdl/ray_triangle_intersect.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect: Moller-Trumbore ray/triangle tester
// Tests a configured ray against a stream of triangles, tracks nearest hit.
// ----------------------------------------------------------------------------
// Usage:
//  - Configure origin, direction, culling and epsilon through cfg_we_i /
//    cfg_idx_i / cfg_data_i while the block is idle.
//  - tri_i takes one triangle request per handshake; each gives exactly one
//    result on res_o: hit flag, closest distance so far, u and v of a hit.
//  - new_ray in a request resets the closest distance before its test.
//  - Per triangle, a passing determinant leads to 24 products on the
//    single shared multiplier and three runs of the bit-serial divider;
//    a rejected determinant ends the work after the first nine products.
//  - A 2-entry queue sits behind tri_i, so up to two triangles wait while
//    one is worked on; res_o has an output register, and the next triangle
//    is computed while a result waits. A stalled res_o holds the sequencer
//    only at its final write.
//  - Reset: ray O=(0,0,0), D=(0,0,1.0), culling on, epsilon 1, closest
//    distance at maximum, queue empty, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_triangle_intersect
  import rti_pkg::*;
#(
  parameter int COORD_WIDTH = CoordWidth,
  parameter int FRAC_BITS   = FracBits
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  wire logic [COORD_WIDTH-1:0] cfg_data_i,
  rti_tri_if.sink                     tri_i,
  rti_res_if.source                   res_o
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = 9 * CW + 1;

  // ray registers
  logic signed [CW-1:0] ox_q, oy_q, oz_q, dx_q, dy_q, dz_q;
  logic                 cull_q;
  logic [EpsWidth-1:0]  eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q   <= '0;
      oy_q   <= '0;
      oz_q   <= '0;
      dx_q   <= '0;
      dy_q   <= '0;
      dz_q   <= CW'(1) << FRAC_BITS;  // unit z
      cull_q <= 1'b1;
      eps_q  <= EpsWidth'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ORIGIN_X: ox_q   <= cfg_data_i;
        CFG_ORIGIN_Y: oy_q   <= cfg_data_i;
        CFG_ORIGIN_Z: oz_q   <= cfg_data_i;
        CFG_DIR_X:    dx_q   <= cfg_data_i;
        CFG_DIR_Y:    dy_q   <= cfg_data_i;
        CFG_DIR_Z:    dz_q   <= cfg_data_i;
        CFG_CULL:     cull_q <= cfg_data_i[0];
        CFG_DET_EPS:  eps_q  <= cfg_data_i[EpsWidth-1:0];
        default: ;
      endcase
    end
  end

  logic          q_valid, q_ready;
  logic [DW-1:0] q_data;

  // front: edge vectors and request queue
  rti_front #(.CW(CW), .DW(DW)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tri_i      (tri_i),
    .origin_x_i (ox_q),
    .origin_y_i (oy_q),
    .origin_z_i (oz_q),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_data_o   (q_data)
  );

  // back: products, determinant test, divides, closest-hit tracking
  rti_back #(.CW(CW), .F(FRAC_BITS), .DW(DW)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .q_data_i  (q_data),
    .dir_x_i   (dx_q),
    .dir_y_i   (dy_q),
    .dir_z_i   (dz_q),
    .cull_i    (cull_q),
    .eps_i     (eps_q),
    .res_o     (res_o)
  );

endmodule

`default_nettype wire

>>> bench/ray_triangle_intersect_tb.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect_tb: self-checking bench for the ray/triangle tester
// Drives triangle requests under varied idling and back-pressure, predicts
// hit, closest distance and barycentrics in fixed point, and compares them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ray_triangle_intersect_tb;
  import rti_pkg::*;

  localparam int CW = CoordWidth;
  localparam int FB = FracBits;
  localparam longint MaxV = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint OneQ = 64'sd1 <<< FB;
  localparam logic [30:0] DistMax = 31'h7FFF_FFFF;
  localparam int StallLimit = 20000;

  typedef struct packed {
    logic        new_ray;
    logic [31:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  } tri_req_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] closest;
    logic [16:0] u;
    logic [16:0] v;
  } hit_rec_t;

  // miss with the distance at its maximum
  localparam hit_rec_t MissFar = '{1'b0, DistMax, 17'd0, 17'd0};

  // directed row: triangle plus optional typed-in expectation
  typedef struct {
    tri_req_t tri_req;
    logic     has_exp;
    hit_rec_t exp_rec;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i = '0;
  logic [CW-1:0] cfg_data_i = '0;

  rti_tri_if #(.CW(CW)) tri_ch ();
  rti_res_if #(.CW(CW), .F(FB)) res_ch ();

  ray_triangle_intersect u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .tri_i(tri_ch.sink), .res_o(res_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor's copy of the ray registers and the closest distance
  longint ray_o[3], ray_d[3];
  logic cull_on;
  logic [15:0] det_eps;
  logic [30:0] nearest;

  hit_rec_t expected_hits[$];
  int errors = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  int hold_off = 0;
  int idle_cycles = 0;

  function automatic longint clamp(longint x);
    if (x > MaxV) return MaxV;
    if (x < -MaxV) return -MaxV;
    return x;
  endfunction

  // 64x64 magnitude product via 128-bit math, shifted and saturated
  function automatic longint qmul(longint a, longint b);
    logic [127:0] p;
    logic [63:0] ma, mb;
    logic [127:0] s;
    longint r;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    p = ma * mb;
    s = p >> FB;
    r = (s > MaxV) ? MaxV : longint'(s);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic longint qdiv(longint n, longint d);
    logic [127:0] mn, md, q;
    longint r;
    mn = (n < 0 ? -n : n);
    mn = mn << FB;
    md = (d < 0 ? -d : d);
    q = mn / md;
    r = (q > MaxV) ? MaxV : longint'(q);
    return ((n < 0) != (d < 0)) ? -r : r;
  endfunction

  function automatic void cross3(input longint a[3], input longint b[3], output longint c[3]);
    c[0] = clamp(qmul(a[1], b[2]) - qmul(a[2], b[1]));
    c[1] = clamp(qmul(a[2], b[0]) - qmul(a[0], b[2]));
    c[2] = clamp(qmul(a[0], b[1]) - qmul(a[1], b[0]));
  endfunction

  function automatic longint dot(input longint a[3], input longint b[3]);
    return clamp(qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2]));
  endfunction

  function automatic hit_rec_t predict(tri_req_t r);
    longint va[3], vb[3], vc[3], e1[3], e2[3], tv[3], p[3], q[3];
    longint det, u, v, t, mag;
    logic ok;
    hit_rec_t h;
    if (r.new_ray) nearest = DistMax;
    va = '{longint'($signed(r.ax)), longint'($signed(r.ay)), longint'($signed(r.az))};
    vb = '{longint'($signed(r.bx)), longint'($signed(r.by)), longint'($signed(r.bz))};
    vc = '{longint'($signed(r.cx)), longint'($signed(r.cy)), longint'($signed(r.cz))};
    for (int k = 0; k < 3; k++) begin
      e1[k] = clamp(vb[k] - va[k]);
      e2[k] = clamp(vc[k] - va[k]);
      tv[k] = clamp(ray_o[k] - va[k]);
    end
    cross3(ray_d, e2, p);
    det = dot(e1, p);
    mag = det < 0 ? -det : det;
    ok = 1'b1;
    u = 0; v = 0;
    if (det == 0) ok = 1'b0;
    else if (cull_on && det < longint'(det_eps)) ok = 1'b0;
    else if (!cull_on && mag < longint'(det_eps)) ok = 1'b0;
    if (ok) begin
      cross3(tv, e1, q);
      u = qdiv(dot(tv, p), det);
      v = qdiv(dot(ray_d, q), det);
      t = qdiv(dot(e2, q), det);
      if (u < 0 || u > OneQ) ok = 1'b0;
      else if (v < 0 || u + v > OneQ) ok = 1'b0;
      else if (t < 0) ok = 1'b0;
      else if (t >= longint'(nearest)) ok = 1'b0;
    end
    if (ok) nearest = t[30:0];
    h.hit = ok;
    h.closest = nearest;
    h.u = ok ? u[16:0] : '0;
    h.v = ok ? v[16:0] : '0;
    return h;
  endfunction

  task automatic report_mismatch(string what, logic [127:0] got, logic [127:0] want);
    $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // the predictor's view of a register write mirrors the block's own
  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ORIGIN_X: ray_o[0] = longint'($signed(val));
      CFG_ORIGIN_Y: ray_o[1] = longint'($signed(val));
      CFG_ORIGIN_Z: ray_o[2] = longint'($signed(val));
      CFG_DIR_X:    ray_d[0] = longint'($signed(val));
      CFG_DIR_Y:    ray_d[1] = longint'($signed(val));
      CFG_DIR_Z:    ray_d[2] = longint'($signed(val));
      CFG_CULL:     cull_on = val[0];
      CFG_DET_EPS:  det_eps = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_ray(logic [31:0] ox, oy, oz, dx, dy, dz, logic cull, logic [15:0] eps);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_DIR_X, dx);
    write_reg(CFG_DIR_Y, dy);
    write_reg(CFG_DIR_Z, dz);
    write_reg(CFG_CULL, {31'd0, cull});
    write_reg(CFG_DET_EPS, {16'd0, eps});
  endtask

  // offer one triangle and hold it until taken; prediction on acceptance
  task automatic send_tri(tri_req_t r, logic has_exp = 1'b0, hit_rec_t e = '0);
    hit_rec_t h;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      tri_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    tri_ch.valid <= 1'b1;
    {tri_ch.new_ray, tri_ch.a_x, tri_ch.a_y, tri_ch.a_z, tri_ch.b_x, tri_ch.b_y,
     tri_ch.b_z, tri_ch.c_x, tri_ch.c_y, tri_ch.c_z} <= r;
    do @(posedge clk_i); while (!tri_ch.ready);
    h = predict(r);
    if (has_exp && h != e) report_mismatch("directed row", 128'(h), 128'(e));
    expected_hits.push_back(has_exp ? e : h);
  endtask

  task automatic drain();
    tri_ch.valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  // random coordinate: mostly small values near the ray, some full range
  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $signed($urandom_range(6 * 65536)) - 3 * 65536;
    endcase
  endfunction

  // triangle straddling the ray, random winding and depth, or one with random coordinates
  function automatic tri_req_t rnd_tri();
    tri_req_t r;
    logic [31:0] z;
    r.new_ray = ($urandom_range(9) == 0);
    if ($urandom_range(4) == 0) begin
      {r.ax, r.ay, r.az, r.bx, r.by, r.bz, r.cx, r.cy, r.cz} =
        {rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
         rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
    end else begin
      z = $signed($urandom_range(20 * 65536)) - 2 * 65536;
      r.ax = -$urandom_range(2 * 65536); r.ay = -$urandom_range(2 * 65536);
      r.bx = $urandom_range(3 * 65536);  r.by = -$urandom_range(2 * 65536);
      r.cx = -$urandom_range(2 * 65536); r.cy = $urandom_range(3 * 65536);
      r.az = z + $urandom_range(65536);
      r.bz = z + $urandom_range(65536);
      r.cz = z + $urandom_range(65536);
      if ($urandom_range(1)) {r.bx, r.by, r.bz, r.cx, r.cy, r.cz} =
                             {r.cx, r.cy, r.cz, r.bx, r.by, r.bz};
    end
    return r;
  endfunction

  // result side: random stall, long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off > 0) begin
        res_ch.ready <= 1'b0;
        hold_off--;
      end else begin
        res_ch.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("unexpected result", 128'(res_ch.hit), 128'(1'b0));
      end else begin
        hit_rec_t e;
        e = expected_hits.pop_front();
        if (res_ch.hit !== e.hit)
          report_mismatch("hit", 128'(res_ch.hit), 128'(e.hit));
        if (res_ch.closest_t !== e.closest)
          report_mismatch("closest_t", 128'(res_ch.closest_t), 128'(e.closest));
        if (res_ch.bary_u !== e.u)
          report_mismatch("bary_u", 128'(res_ch.bary_u), 128'(e.u));
        if (res_ch.bary_v !== e.v)
          report_mismatch("bary_v", 128'(res_ch.bary_v), 128'(e.v));
      end
    end
  end

  // watchdog: cycles with no request moving on either side
  always @(posedge clk_i) begin
    if ((tri_ch.valid && tri_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles <= 0;
    else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("ray_triangle_intersect_tb failed");
        $finish;
      end
    end
  end

  localparam logic [31:0] One = 32'h0001_0000;
  dir_row_t dir_rows[$];

  function automatic tri_req_t mk_tri(logic nr, logic [31:0] ax, ay, az, bx, by, bz,
                                      cx, cy, cz);
    return {nr, ax, ay, az, bx, by, bz, cx, cy, cz};
  endfunction

  task automatic add_row(tri_req_t r, logic has = 1'b0, hit_rec_t e = '0);
    dir_row_t d;
    d.tri_req = r; d.has_exp = has; d.exp_rec = e;
    dir_rows.push_back(d);
  endtask

  initial begin
    tri_req_t r;
    tri_ch.valid = 1'b0;
    tri_ch.new_ray = 1'b0;
    {tri_ch.a_x, tri_ch.a_y, tri_ch.a_z, tri_ch.b_x, tri_ch.b_y, tri_ch.b_z,
     tri_ch.c_x, tri_ch.c_y, tri_ch.c_z} = '0;
    ray_o = '{0, 0, 0};
    ray_d = '{0, 0, OneQ};
    cull_on = 1'b1;
    det_eps = 16'd1;
    nearest = DistMax;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset ray along +z. Degenerate triangle: zero determinant miss.
    add_row(mk_tri(1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, MissFar);
    // unit triangle at z=2, back-facing under culling: rejected
    add_row(mk_tri(1'b0, 0, 0, 2 * One, One, 0, 2 * One, 0, One, 2 * One));
    // same at z=3: also back-facing, rejected, distance kept
    add_row(mk_tri(1'b0, 0, 0, 3 * One, One, 0, 3 * One, 0, One, 3 * One));
    // at z=1: back-facing first; then the flipped winding is a hit
    add_row(mk_tri(1'b0, -One, -One, One, One, -One, One, -One, One, One));
    add_row(mk_tri(1'b0, -One, -One, One, -One, One, One, One, -One, One));
    // new ray restarts the distance; triangle behind origin (t<0), back-facing
    add_row(mk_tri(1'b1, -One, -One, -One, One, -One, -One, -One, One, -One));
    // u and v beyond the edge; exactly on edge u+v=1; both back-facing
    add_row(mk_tri(1'b0, One, One, One, 2 * One, One, One, One, 2 * One, One));
    add_row(mk_tri(1'b0, -One, 0, One, One, 0, One, -One, 2 * One, One));
    // full-scale extremes saturate everywhere
    add_row(mk_tri(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    add_row(mk_tri(1'b0, '1, '1, '1, '1, '1, '1, '1, '1, '1));
    add_row(mk_tri(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    // tiny triangle: determinant below one raw unit, rejected
    add_row(mk_tri(1'b1, 0, 0, One, 1, 0, One, 0, 1, One), 1'b1, MissFar);
    foreach (dir_rows[i]) send_tri(dir_rows[i].tri_req, dir_rows[i].has_exp,
                                   dir_rows[i].exp_rec);
    drain();

    // no culling, large epsilon, tilted ray: back faces and epsilon edge
    set_ray(32'h0000_4000, 32'hFFFF_C000, 32'hFFFE_0000, 32'h0000_1000, 32'hFFFF_F000,
            One, 1'b0, 16'hFFFF);
    send_tri(mk_tri(1'b1, -One, -One, One, -One, One, One, One, -One, One));
    send_tri(mk_tri(1'b0, -4 * One, -4 * One, 2 * One, -4 * One, 4 * One, 2 * One,
                    4 * One, -4 * One, 2 * One));
    send_tri(mk_tri(1'b0, 0, 0, One, 32'h0000_FFFF, 0, One, 0, One, One));
    drain();
    // epsilon 0 with culling off: zero determinant still rejected
    set_ray(0, 0, 0, 0, 0, One, 1'b0, 16'h0000);
    send_tri(mk_tri(1'b1, 0, 0, One, One, 0, One, 2 * One, 0, One), 1'b1, MissFar);
    drain();

    // random phases with different rays and idling
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_ray(0, 0, 0, 0, 0, One, 1'b1, 16'd1);
        1: set_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF,
                   1'b0, 16'd0);
        2: set_ray($urandom_range(65536), $urandom_range(65536), -2 * One,
                   $urandom_range(8192), $urandom_range(8192), One, 1'b0, 16'd1);
        3: set_ray(0, 0, 32'h0010_0000, 0, 0, -One, 1'b0, 16'd16);
        4: set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   1'($urandom), 16'($urandom));
        default: set_ray(0, 0, -One, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         1'b1, 16'hFFFF);
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      // long hold-off of the result side while triangles keep coming
      if (ph == 0) hold_off = 2000;
      for (int n = 0; n < 220; n++) begin
        r = rnd_tri();
        if (ph == 3) begin
          r.az = -r.az; r.bz = -r.bz; r.cz = -r.cz;
        end
        send_tri(r);
      end
      drain();
    end

    if (errors == 0) begin
      $display("ray_triangle_intersect_tb passed");
    end else begin
      $display("ray_triangle_intersect_tb failed");
    end
    $finish;
  end

endmodule

>>> ray_triangle_intersect.f
hdl/rti_pkg.sv
hdl/rti_tri_if.sv
hdl/rti_res_if.sv
hdl/rti_front.sv
hdl/rti_div.sv
hdl/rti_back.sv
hdl/ray_triangle_intersect.sv
bench/ray_triangle_intersect_tb.sv
